// ===== src/ring_deque_push_rear_pop_both_core_defines.svh =====
// assertion macros for the ring deque core and its checker
`ifndef RING_DEQUE_PUSH_REAR_POP_BOTH_CORE_DEFINES_SVH
`define RING_DEQUE_PUSH_REAR_POP_BOTH_CORE_DEFINES_SVH

// concurrent assertion on an explicit clock and active-low reset
`define RDQ_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion on the default clock and reset names
`define RDQ_ASSERT(label, prop, msg) \
  `RDQ_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== src/rdq_pkg.sv =====
// shared types and constants of the ring deque core
`default_nettype none

package rdq_pkg;

  localparam int unsigned DEPTH_DEF = 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_REAR = 2'd0,
    CMD_POP_FRONT = 2'd1,
    CMD_POP_REAR  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic exec;
  } ctl_cmd_t;

endpackage

`default_nettype wire

// ===== src/rdq_in_if.sv =====
// command channel of the ring deque core
`default_nettype none

interface rdq_in_if;
  logic                                valid;
  logic                                ready;
  logic [rdq_pkg::CMD_W-1:0]           command;
  logic signed [rdq_pkg::DATA_W-1:0]   push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

`default_nettype wire

// ===== src/rdq_out_if.sv =====
// result channel of the ring deque core
`default_nettype none

interface rdq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rdq_pkg::DATA_W-1:0]   popped_value;
  logic [rdq_pkg::STATUS_W-1:0]        status;
  logic                                now_empty;
  logic                                now_full;

  modport source (output valid, output popped_value, output status, output now_empty,
                  output now_full, input ready);
  modport sink   (input valid, input popped_value, input status, input now_empty,
                  input now_full, output ready);
endinterface

`default_nettype wire

// ===== src/rdq_ctrl.sv =====
// handshake controller of the ring deque core
`default_nettype none

module rdq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rdq_pkg::ctl_cmd_t      cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_q, state_d;
  logic exec;

  // a held result leaving this cycle frees the output register
  assign in_ready_o  = (state_q == S_IDLE) || out_ready_i;
  assign exec        = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_HOLD);
  assign cmd_o.exec  = exec;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (exec) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (exec) state_d = S_HOLD;
        else if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/rdq_datapath.sv =====
// pointers, slot memory and result registers of the ring deque core
`default_nettype none

module rdq_datapath #(
  parameter int unsigned DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire rdq_pkg::ctl_cmd_t                 cmd_i,
  input  wire logic [rdq_pkg::CMD_W-1:0]         command_i,
  input  wire logic signed [rdq_pkg::DATA_W-1:0] push_value_i,
  output logic signed [rdq_pkg::DATA_W-1:0]      popped_value_o,
  output logic [rdq_pkg::STATUS_W-1:0]           status_o,
  output logic                                   now_empty_o,
  output logic                                   now_full_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [rdq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [rdq_pkg::DATA_W-1:0] rdata_q;

  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic          empty_q, empty_d;
  logic          pop_ok_q, pop_ok_d;
  rdq_pkg::status_e status_q, status_d;

  logic [AW-1:0] head_fwd, tail_fwd, tail_back;
  logic [AW-1:0] waddr, raddr;
  logic          we, re, full, last;

  assign head_fwd  = (head_q == LAST_IDX) ? '0 : AW'(head_q + AW'(1));
  assign tail_fwd  = (tail_q == LAST_IDX) ? '0 : AW'(tail_q + AW'(1));
  assign tail_back = (tail_q == '0) ? LAST_IDX : AW'(tail_q - AW'(1));
  assign full      = !empty_q && (tail_fwd == head_q);
  assign last      = (head_q == tail_q);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    empty_d  = empty_q;
    pop_ok_d = 1'b0;
    status_d = rdq_pkg::ST_OK;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = empty_q ? '0 : tail_fwd;
    raddr    = tail_q;
    case (rdq_pkg::cmd_e'(command_i))
      rdq_pkg::CMD_PUSH_REAR: begin
        if (full) begin
          status_d = rdq_pkg::ST_OVERFLOW;
        end else begin
          we      = 1'b1;
          tail_d  = waddr;
          empty_d = 1'b0;
          if (empty_q) head_d = '0;
        end
      end
      rdq_pkg::CMD_POP_FRONT, rdq_pkg::CMD_POP_REAR: begin
        if (empty_q) begin
          status_d = rdq_pkg::ST_UNDERFLOW;
        end else begin
          re       = 1'b1;
          pop_ok_d = 1'b1;
          if (rdq_pkg::cmd_e'(command_i) == rdq_pkg::CMD_POP_FRONT) begin
            raddr = head_q;
            if (!last) head_d = head_fwd;
          end else begin
            raddr = tail_q;
            if (!last) tail_d = tail_back;
          end
          if (last) begin
            empty_d = 1'b1;
            head_d  = '0;
            tail_d  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // slot memory, one access per command
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) mem[waddr] <= push_value_i;
    if (cmd_i.exec && re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      empty_q  <= 1'b1;
      pop_ok_q <= 1'b0;
      status_q <= rdq_pkg::ST_OK;
    end else if (cmd_i.exec) begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      empty_q  <= empty_d;
      pop_ok_q <= pop_ok_d;
      status_q <= status_d;
    end
  end

  // flags come straight from the state the command left behind
  assign popped_value_o = pop_ok_q ? rdata_q : '0;
  assign status_o       = status_q;
  assign now_empty_o    = empty_q;
  assign now_full_o     = full;

endmodule

`default_nettype wire

// ===== src/ring_deque_push_rear_pop_both_core.sv =====
// ring deque core: result valid in the cycle after the command transfer
// throughput one command per cycle while the result side keeps ready high
// the output register holds a result; the next command is taken when it leaves
// slot access is a single memory port with a registered read
// reset clears pointers and marks the buffer empty; slot memory is not cleared
`default_nettype none

module ring_deque_push_rear_pop_both_core #(
  parameter int unsigned DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rdq_in_if.sink     in_i,
  rdq_out_if.source  out_o
);

  rdq_pkg::ctl_cmd_t ctl_cmd;

  // controller: decides when a command transfer happens and when a result is shown
  rdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (ctl_cmd)
  );

  // datapath: front and rear pointers, empty flag, slot memory, result registers
  rdq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctl_cmd),
    .command_i      (in_i.command),
    .push_value_i   (in_i.push_value),
    .popped_value_o (out_o.popped_value),
    .status_o       (out_o.status),
    .now_empty_o    (out_o.now_empty),
    .now_full_o     (out_o.now_full)
  );

endmodule

`default_nettype wire

// ===== src/rdq_checker.sv =====
// port-level checker of the ring deque core and its bind
`default_nettype none
`include "ring_deque_push_rear_pop_both_core_defines.svh"

module rdq_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [rdq_pkg::DATA_W-1:0] popped_value,
  input wire logic [rdq_pkg::STATUS_W-1:0]      status,
  input wire logic                              now_empty,
  input wire logic                              now_full
);

  `RDQ_ASSERT(a_valid_holds, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `RDQ_ASSERT(a_flags_excl, out_valid |-> !(now_empty && now_full), "empty and full together")
  `RDQ_ASSERT(a_ovf_full,
              out_valid && status == rdq_pkg::ST_OVERFLOW |-> now_full,
              "overflow while not full")
  `RDQ_ASSERT(a_udf_empty,
              out_valid && status == rdq_pkg::ST_UNDERFLOW |-> now_empty && popped_value == '0,
              "bad underflow result")

endmodule

bind ring_deque_push_rear_pop_both_core rdq_checker u_rdq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .popped_value (out_o.popped_value),
  .status       (out_o.status),
  .now_empty    (out_o.now_empty),
  .now_full     (out_o.now_full)
);

`default_nettype wire
